// ----- sv/fa_pkg.sv -----
package fa_pkg;

    // Table geometry
    localparam int MAX_SEGMENTS = 16;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
    localparam int DATA_W       = 16;

    localparam logic [DATA_W-1:0] POOL_RESET = 16'd256;

    // Request kinds carried on s_tuser
    typedef enum logic [1:0] {
        OP_FIRST = 2'd0,
        OP_BEST  = 2'd1,
        OP_WORST = 2'd2,
        OP_FREE  = 2'd3
    } op_t;

    // Result codes carried on m_tuser
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FIT    = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // One segment table entry
    typedef struct packed {
        logic [DATA_W-1:0] start;
        logic [DATA_W-1:0] length;
        logic              is_free;
    } seg_t;

    // Write request into the segment table
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        seg_t             seg;
    } tbl_wr_t;

endpackage

// ----- sv/fa_table.sv -----
module fa_table
    import fa_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              init_en,
    input  logic [DATA_W-1:0] init_len,
    input  tbl_wr_t           wr,
    input  logic [IDX_W-1:0]  rd_idx,
    output seg_t              rd_seg
);

    // Entries other than entry 0 hold nothing until written
    seg_t seg_reg [MAX_SEGMENTS];

    // Reset and pool reload rebuild entry 0 as one free segment
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_reg[0] <= '{start: '0, length: POOL_RESET, is_free: 1'b1};
        end else if (init_en) begin
            seg_reg[0] <= '{start: '0, length: init_len, is_free: 1'b1};
        end else if (wr.en) begin
            seg_reg[wr.idx] <= wr.seg;
        end
    end

    // Single read port
    assign rd_seg = seg_reg[rd_idx];

endmodule

// ----- sv/fit_allocator_with_coalescing_core.sv -----
// Segment allocator with first, best and worst fit and coalescing on free.
// Input channel s_*: one word per request; s_tuser selects the operation and
// s_tdata carries request size and free address. Result channel m_*: one word
// per request with the status on m_tuser and the granted start on m_tdata.
// A sequencer walks the 16-entry segment table one entry per cycle through a
// single read port, one write port and one shared add/subtract unit.
// Allocate scans the live entries, stopping at the first fit for first fit,
// then fails (no fit, or a full table for a split), marks an exact fit, or
// moves later entries up to split off the free remainder; a zero-size
// allocate skips the scan with no fit. Free scans up to the matching start,
// then merges with a free next and then a free previous neighbour, moving
// later entries down for each merge; a miss scans every live entry. One
// request is in work at a time; s_tready is high only in idle, which the
// sequencer enters as it hands the word to the output register.
// The finished word waits in the output register, so a new request is taken
// while the receiver stalls; a second result then holds the sequencer until
// the first word is taken.
// Reset (aresetn low, synchronous) and a cfg_we pool size write leave one
// free segment for the whole pool; use cfg_we only idle (block won't check).
module fit_allocator_with_coalescing_core
    import fa_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // Pool size register
    input  logic              cfg_we,
    input  logic [DATA_W-1:0] cfg_wdata,
    // Request channel
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,   // [15:0] request_size, [31:16] free_address
    input  logic [1:0]        s_tuser,   // [1:0] operation
    // Result channel
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,   // [15:0] address
    output logic [1:0]        m_tuser    // [1:0] status
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT_UP,
        S_SPLIT_LEN,
        S_SPLIT_WR,
        S_MARK,
        S_FIND,
        S_NEXT,
        S_SHIFT_DN,
        S_PREV,
        S_FINISH
    } state_t;

    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SEGMENTS);

    state_t            state_reg,      state_next;
    op_t               op_reg,         op_next;
    logic [DATA_W-1:0] want_reg,       want_next;
    logic [DATA_W-1:0] where_reg,      where_next;
    logic [CNT_W-1:0]  count_reg,      count_next;
    logic [CNT_W-1:0]  i_reg,          i_next;
    logic [IDX_W-1:0]  pick_reg,       pick_next;
    logic [DATA_W-1:0] pick_len_reg,   pick_len_next;
    logic [DATA_W-1:0] pick_start_reg, pick_start_next;
    logic              found_reg,      found_next;
    logic [DATA_W-1:0] cur_len_reg,    cur_len_next;
    logic              phase_reg,      phase_next;
    status_t           status_reg,     status_next;
    logic [DATA_W-1:0] addr_reg,       addr_next;
    logic              m_valid_reg,    m_valid_next;
    status_t           m_status_reg,   m_status_next;
    logic [DATA_W-1:0] m_addr_reg,     m_addr_next;

    tbl_wr_t           tbl_wr;
    logic [IDX_W-1:0]  rd_idx;
    seg_t              rd_seg;

    logic [DATA_W-1:0] alu_a, alu_b, alu_b_eff, alu_sum;
    logic              alu_sub;

    logic [CNT_W-1:0]  pick_ext;
    logic              fits;

    fa_table u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .init_en  (cfg_we),
        .init_len (cfg_wdata),
        .wr       (tbl_wr),
        .rd_idx   (rd_idx),
        .rd_seg   (rd_seg)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_addr_reg;
    assign m_tuser  = m_status_reg;

    assign pick_ext = {1'b0, pick_reg};
    assign fits     = rd_seg.is_free && (rd_seg.length >= want_reg);

    // Shared add/subtract unit
    assign alu_b_eff = alu_sub ? ~alu_b : alu_b;
    assign alu_sum   = alu_a + alu_b_eff + {{(DATA_W-1){1'b0}}, alu_sub};

    // Table read address per step
    always_comb begin
        case (state_reg)
            S_SCAN, S_FIND: rd_idx = i_reg[IDX_W-1:0];
            S_SHIFT_UP:     rd_idx = IDX_W'(i_reg - CNT_ONE);
            S_SHIFT_DN:     rd_idx = IDX_W'(i_reg + CNT_ONE);
            S_NEXT:         rd_idx = pick_reg + IDX_W'(1);
            S_PREV:         rd_idx = pick_reg - IDX_W'(1);
            default:        rd_idx = pick_reg;
        endcase
    end

    // ALU operand selection
    always_comb begin
        alu_a   = cur_len_reg;
        alu_b   = rd_seg.length;
        alu_sub = 1'b0;
        case (state_reg)
            S_SPLIT_LEN: begin
                alu_a   = pick_len_reg;
                alu_b   = want_reg;
                alu_sub = 1'b1;
            end
            S_SPLIT_WR: begin
                alu_a = pick_start_reg;
                alu_b = want_reg;
            end
            default: begin
                alu_a = cur_len_reg;
                alu_b = rd_seg.length;
            end
        endcase
    end

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        want_next       = want_reg;
        where_next      = where_reg;
        count_next      = count_reg;
        i_next          = i_reg;
        pick_next       = pick_reg;
        pick_len_next   = pick_len_reg;
        pick_start_next = pick_start_reg;
        found_next      = found_reg;
        cur_len_next    = cur_len_reg;
        phase_next      = phase_reg;
        status_next     = status_reg;
        addr_next       = addr_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_addr_next     = m_addr_reg;
        tbl_wr          = '0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next     = op_t'(s_tuser);
                    want_next   = s_tdata[15:0];
                    where_next  = s_tdata[31:16];
                    i_next      = '0;
                    found_next  = 1'b0;
                    addr_next   = '0;
                    status_next = ST_OK;
                    if (op_t'(s_tuser) == OP_FREE) begin
                        state_next = S_FIND;
                    end else if (s_tdata[15:0] == '0) begin
                        status_next = ST_NO_FIT;
                        state_next  = S_FINISH;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end

            // walk live entries, keep the candidate by policy
            S_SCAN: begin
                if (i_reg == count_reg) begin
                    state_next = S_DECIDE;
                end else begin
                    i_next = i_reg + CNT_ONE;
                    if (fits) begin
                        if (!found_reg) begin
                            found_next      = 1'b1;
                            pick_next       = i_reg[IDX_W-1:0];
                            pick_len_next   = rd_seg.length;
                            pick_start_next = rd_seg.start;
                            if (op_reg == OP_FIRST) begin
                                state_next = S_DECIDE;
                            end
                        end else if ((op_reg == OP_BEST && rd_seg.length < pick_len_reg) ||
                                     (op_reg == OP_WORST && rd_seg.length > pick_len_reg)) begin
                            pick_next       = i_reg[IDX_W-1:0];
                            pick_len_next   = rd_seg.length;
                            pick_start_next = rd_seg.start;
                        end
                    end
                end
            end

            S_DECIDE: begin
                if (!found_reg) begin
                    status_next = ST_NO_FIT;
                    state_next  = S_FINISH;
                end else if (pick_len_reg == want_reg) begin
                    state_next = S_MARK;
                end else if (count_reg == CNT_MAX) begin
                    status_next = ST_FULL;
                    state_next  = S_FINISH;
                end else begin
                    i_next     = count_reg;
                    state_next = S_SHIFT_UP;
                end
            end

            // open a slot after the pick, one entry per cycle
            S_SHIFT_UP: begin
                if (i_reg > pick_ext + CNT_ONE) begin
                    tbl_wr.en  = 1'b1;
                    tbl_wr.idx = i_reg[IDX_W-1:0];
                    tbl_wr.seg = rd_seg;
                    i_next     = i_reg - CNT_ONE;
                end else begin
                    state_next = S_SPLIT_LEN;
                end
            end

            S_SPLIT_LEN: begin
                cur_len_next = alu_sum;
                state_next   = S_SPLIT_WR;
            end

            // free remainder after the pick
            S_SPLIT_WR: begin
                tbl_wr.en          = 1'b1;
                tbl_wr.idx         = pick_reg + IDX_W'(1);
                tbl_wr.seg.start   = alu_sum;
                tbl_wr.seg.length  = cur_len_reg;
                tbl_wr.seg.is_free = 1'b1;
                count_next         = count_reg + CNT_ONE;
                state_next         = S_MARK;
            end

            S_MARK: begin
                tbl_wr.en          = 1'b1;
                tbl_wr.idx         = pick_reg;
                tbl_wr.seg.start   = pick_start_reg;
                tbl_wr.seg.length  = want_reg;
                tbl_wr.seg.is_free = 1'b0;
                status_next        = ST_OK;
                addr_next          = pick_start_reg;
                state_next         = S_FINISH;
            end

            // look for the exact start
            S_FIND: begin
                if (i_reg == count_reg) begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_FINISH;
                end else if (rd_seg.start == where_reg) begin
                    pick_next    = i_reg[IDX_W-1:0];
                    cur_len_next = rd_seg.length;
                    state_next   = S_NEXT;
                end else begin
                    i_next = i_reg + CNT_ONE;
                end
            end

            // merge with a free next segment
            S_NEXT: begin
                if ((pick_ext + CNT_ONE < count_reg) && rd_seg.is_free) begin
                    cur_len_next = alu_sum;
                    i_next       = pick_ext + CNT_ONE;
                    phase_next   = 1'b0;
                    state_next   = S_SHIFT_DN;
                end else begin
                    state_next = S_PREV;
                end
            end

            // remove entry i, pulling later entries down
            S_SHIFT_DN: begin
                if (i_reg + CNT_ONE < count_reg) begin
                    tbl_wr.en  = 1'b1;
                    tbl_wr.idx = i_reg[IDX_W-1:0];
                    tbl_wr.seg = rd_seg;
                    i_next     = i_reg + CNT_ONE;
                end else begin
                    count_next = count_reg - CNT_ONE;
                    if (phase_reg) begin
                        status_next = ST_OK;
                        state_next  = S_FINISH;
                    end else begin
                        state_next = S_PREV;
                    end
                end
            end

            // merge into a free previous segment, or write back the freed one
            S_PREV: begin
                tbl_wr.en = 1'b1;
                if ((pick_reg != '0) && rd_seg.is_free) begin
                    tbl_wr.idx         = pick_reg - IDX_W'(1);
                    tbl_wr.seg.start   = rd_seg.start;
                    tbl_wr.seg.length  = alu_sum;
                    tbl_wr.seg.is_free = 1'b1;
                    i_next             = pick_ext;
                    phase_next         = 1'b1;
                    state_next         = S_SHIFT_DN;
                end else begin
                    tbl_wr.idx         = pick_reg;
                    tbl_wr.seg.start   = where_reg;
                    tbl_wr.seg.length  = cur_len_reg;
                    tbl_wr.seg.is_free = 1'b1;
                    status_next        = ST_OK;
                    state_next         = S_FINISH;
                end
            end

            // hand the word to the output register once it is free
            S_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_addr_next   = addr_reg;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        // pool reload leaves one segment
        if (cfg_we) begin
            count_next = CNT_ONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= CNT_ONE;
            m_valid_reg <= 1'b0;
            found_reg   <= 1'b0;
            phase_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            found_reg   <= found_next;
            phase_reg   <= phase_next;
        end
        op_reg         <= op_next;
        want_reg       <= want_next;
        where_reg      <= where_next;
        i_reg          <= i_next;
        pick_reg       <= pick_next;
        pick_len_reg   <= pick_len_next;
        pick_start_reg <= pick_start_next;
        cur_len_reg    <= cur_len_next;
        status_reg     <= status_next;
        addr_reg       <= addr_next;
        m_status_reg   <= m_status_next;
        m_addr_reg     <= m_addr_next;
    end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb
    import fa_pkg::*;
();

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [15:0] request_size, [31:16] free_address
    logic [1:0]  s_tuser;   // [1:0] operation
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [15:0] address
    logic [1:0]  m_tuser;   // [1:0] status

    // One reply word as the block should return it
    typedef struct packed {
        status_t     status;
        logic [15:0] address;
    } reply_t;

    // Segment table mirror: predicts each reply and checks what comes back
    class segment_ledger;
        logic [15:0] seg_start [MAX_SEGMENTS];
        logic [15:0] seg_len [MAX_SEGMENTS];
        bit          seg_free [MAX_SEGMENTS];
        int          seg_count;
        reply_t      replies_due [$];
        int          mismatches;

        function void reset_table(logic [15:0] pool);
            int i;
            for (i = 0; i < MAX_SEGMENTS; i++) begin
                seg_start[i] = '0;
                seg_len[i]   = '0;
                seg_free[i]  = 1'b0;
            end
            seg_len[0]  = pool;
            seg_free[0] = 1'b1;
            seg_count   = 1;
        endfunction

        function void drop_entry(int k);
            int j;
            for (j = k; j + 1 < seg_count; j++) begin
                seg_start[j] = seg_start[j + 1];
                seg_len[j]   = seg_len[j + 1];
                seg_free[j]  = seg_free[j + 1];
            end
            seg_count--;
        endfunction

        function reply_t grant(op_t op, logic [15:0] want);
            reply_t r;
            int     i;
            int     pick;
            bit     found;
            r.status  = ST_NO_FIT;
            r.address = '0;
            pick      = 0;
            found     = 1'b0;
            if (want == 0)
                return r;
            // scan by policy; ties keep the earliest entry
            for (i = 0; i < seg_count; i++) begin
                if (!seg_free[i] || seg_len[i] < want)
                    continue;
                if (!found) begin
                    pick  = i;
                    found = 1'b1;
                    if (op == OP_FIRST)
                        break;
                end else if (op == OP_BEST && seg_len[i] < seg_len[pick]) begin
                    pick = i;
                end else if (op == OP_WORST && seg_len[i] > seg_len[pick]) begin
                    pick = i;
                end
            end
            if (!found)
                return r;
            // split off the free tail unless the fit is exact
            if (seg_len[pick] != want) begin
                if (seg_count >= MAX_SEGMENTS) begin
                    r.status = ST_FULL;
                    return r;
                end
                for (i = seg_count; i > pick + 1; i--) begin
                    seg_start[i] = seg_start[i - 1];
                    seg_len[i]   = seg_len[i - 1];
                    seg_free[i]  = seg_free[i - 1];
                end
                seg_start[pick + 1] = seg_start[pick] + want;
                seg_len[pick + 1]   = seg_len[pick] - want;
                seg_free[pick + 1]  = 1'b1;
                seg_count++;
                seg_len[pick] = want;
            end
            seg_free[pick] = 1'b0;
            r.status  = ST_OK;
            r.address = seg_start[pick];
            return r;
        endfunction

        function status_t release_at(logic [15:0] where);
            int i;
            for (i = 0; i < seg_count; i++)
                if (seg_start[i] == where)
                    break;
            if (i >= seg_count)
                return ST_NOT_FOUND;
            seg_free[i] = 1'b1;
            // coalesce with the next, then the previous neighbor
            if (i + 1 < seg_count && seg_free[i + 1]) begin
                seg_len[i] += seg_len[i + 1];
                drop_entry(i + 1);
            end
            if (i > 0 && seg_free[i - 1]) begin
                seg_len[i - 1] += seg_len[i];
                drop_entry(i);
            end
            return ST_OK;
        endfunction

        function void note_request(op_t op, logic [15:0] want, logic [15:0] where);
            reply_t r;
            if (op == OP_FREE) begin
                r.status  = release_at(where);
                r.address = '0;
            end else begin
                r = grant(op, want);
            end
            replies_due.push_back(r);
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        task check_result(logic [1:0] status, logic [15:0] address);
            reply_t due;
            if (replies_due.size() == 0) begin
                report($sformatf("unexpected word status %0d address %h", status, address));
                return;
            end
            due = replies_due.pop_front();
            if (status !== due.status)
                report($sformatf("status %0d, want %s", status, due.status.name()));
            if (address !== due.address)
                report($sformatf("address %h, want %h", address, due.address));
        endtask

        function int pending();
            return replies_due.size();
        endfunction

        // start of a random segment that is used (or free)
        function bit random_start(bit want_free, output logic [15:0] where);
            int hits [$];
            int i;
            where = '0;
            for (i = 0; i < seg_count; i++)
                if (seg_free[i] == want_free)
                    hits.push_back(i);
            if (hits.size() == 0)
                return 1'b0;
            where = seg_start[hits[$urandom_range(0, hits.size() - 1)]];
            return 1'b1;
        endfunction

        // length of a random free segment, for exact fits
        function bit random_free_len(output logic [15:0] len);
            int hits [$];
            int i;
            len = '0;
            for (i = 0; i < seg_count; i++)
                if (seg_free[i])
                    hits.push_back(i);
            if (hits.size() == 0)
                return 1'b0;
            len = seg_len[hits[$urandom_range(0, hits.size() - 1)]];
            return 1'b1;
        endfunction
    endclass

    segment_ledger ledger;
    int            pool_units;
    int            send_calm;
    int            take_calm;

    fit_allocator_with_coalescing_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // random wait, with occasional runs of back-to-back traffic
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
            calm = $urandom_range(10, 40);
        return $urandom_range(0, 13);
    endfunction

    task automatic send(op_t op, logic [15:0] want, logic [15:0] where);
        int gap;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {where, want};
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        ledger.note_request(op, want, where);
    endtask

    // pool size write, only once the block has drained
    task automatic set_pool(logic [15:0] size);
        s_tvalid <= 1'b0;
        while (ledger.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wdata <= size;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we <= 1'b0;
        ledger.reset_table(size);
        pool_units = int'(size);
    endtask

    // mostly frees of live allocations and sized allocates, some noise
    task automatic random_request();
        int          pick;
        int          lim;
        bit          ok;
        logic [15:0] where;
        logic [15:0] len;
        logic [15:0] hole;
        ok    = 1'b0;
        pick  = $urandom_range(0, 99);
        where = 16'($urandom_range(0, 65535));
        if (pick >= 50) begin
            if (pick < 88)
                ok = ledger.random_start(1'b0, where);
            else if (pick < 94)
                ok = ledger.random_start(1'b1, where);
            else
                ok = 1'b1;
            if (ok) begin
                send(OP_FREE, 16'($urandom_range(0, 65535)), where);
                return;
            end
            where = 16'($urandom_range(0, 65535));
        end
        lim = ($urandom_range(0, 1) != 0) ? pool_units / 4 : pool_units / 32;
        if (lim < 1)
            lim = 1;
        len  = 16'($urandom_range(1, lim));
        pick = $urandom_range(0, 19);
        if (pick == 0)
            len = '0;
        else if (pick == 1)
            len = 16'($urandom_range(0, 65535));
        else if (pick < 5 && ledger.random_free_len(hole))
            len = hole;
        send(op_t'($urandom_range(0, 2)), len, where);
    endtask

    // result side: random stalls, check every word taken
    initial begin
        int stall;
        m_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = draw_wait(take_calm);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            ledger.check_result(m_tuser, m_tdata);
        end
    end

    // request side
    initial begin
        int          done;
        int          phase;
        logic [15:0] hole;
        ledger = new();
        ledger.reset_table(POOL_RESET);
        pool_units = int'(POOL_RESET);
        send_calm  = 0;
        take_calm  = 0;
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= OP_FIRST;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed on the reset pool of 256
        send(OP_FIRST, 16'd0, 16'hFFFF);      // zero request
        send(OP_WORST, 16'hFFFF, 16'd0);      // larger than the pool
        send(OP_FIRST, 16'd64, 16'd0);
        send(OP_FIRST, 16'd64, 16'd0);
        send(OP_FIRST, 16'd64, 16'd0);
        send(OP_FREE, 16'd0, 16'd0);
        send(OP_WORST, 16'd8, 16'd0);         // two largest holes tie
        send(OP_BEST, 16'd56, 16'd0);         // exact fit
        send(OP_FREE, 16'd0, 16'd64);
        send(OP_BEST, 16'd10, 16'd0);         // two smallest holes tie
        send(OP_FREE, 16'd0, 16'd74);         // already free
        send(OP_FREE, 16'd0, 16'd75);         // no segment starts here
        send(OP_FREE, 16'd0, 16'd64);         // merge with next
        send(OP_FREE, 16'd0, 16'd128);        // merge both sides
        // fill the table until a split is refused
        repeat (14) send(OP_FIRST, 16'd1, 16'd0);
        if (ledger.random_free_len(hole))
            send(OP_BEST, hole, 16'd0);       // exact fit on a full table
        send(OP_BEST, 16'd2, 16'd0);

        // empty pool
        set_pool(16'd0);
        send(OP_FIRST, 16'd1, 16'd0);
        send(OP_FREE, 16'd0, 16'd0);

        // random phases, extremes of the pool first
        done  = 0;
        phase = 0;
        while (done < 1250) begin
            case (phase)
                0: set_pool(16'd1);
                1: set_pool(16'hFFFF);
                default: begin
                    if ($urandom_range(0, 3) == 0)
                        set_pool(16'($urandom_range(0, 65535)));
                    else
                        set_pool(16'($urandom_range(8, 400)));
                end
            endcase
            repeat ($urandom_range(30, 150)) begin
                if (done < 1250) begin
                    random_request();
                    done++;
                end
            end
            phase++;
        end

        // drain, then allow for the longest request
        s_tvalid <= 1'b0;
        while (ledger.pending() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (ledger.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // watchdog
    initial begin
        #1000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- fit_allocator_with_coalescing_core.f -----
sv/fa_pkg.sv
sv/fa_table.sv
sv/fit_allocator_with_coalescing_core.sv
verif/tb.sv
